[rtl/rpfp_pkg.sv]
package rpfp_pkg;

	localparam int unsigned PIXEL_W    = 32;
	localparam int unsigned FIELD_W    = 11;
	localparam int unsigned BPP_W      = 6;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = FIELD_W;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIXEL_BITS  = 3'd0,
		REG_RED_FIELD   = 3'd1,
		REG_GREEN_FIELD = 3'd2,
		REG_BLUE_FIELD  = 3'd3,
		REG_ALPHA_FIELD = 3'd4,
		REG_SRC_ALPHA   = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_BAD_WIDTH   = 2'd1,
		ST_BAD_CHANNEL = 2'd2,
		ST_OVERLAP     = 2'd3
	} status_t;

	localparam logic [BPP_W-1:0]   PIXEL_BITS_RST  = 6'd32;
	localparam logic [FIELD_W-1:0] RED_FIELD_RST   = 11'd272;
	localparam logic [FIELD_W-1:0] GREEN_FIELD_RST = 11'd264;
	localparam logic [FIELD_W-1:0] BLUE_FIELD_RST  = 11'd256;
	localparam logic [FIELD_W-1:0] ALPHA_FIELD_RST = 11'd280;

	// Channel fits in the pixel: size <= bpp and offset <= bpp - size
	function automatic logic fld_fits(logic [FIELD_W-1:0] f, logic [BPP_W-1:0] bpp);
		return (7'(f[4:0]) + 7'(f[10:5])) <= 7'(bpp);
	endfunction

	// Bit mask of a channel that already passed the fit check
	function automatic logic [PIXEL_W-1:0] fld_mask(logic [FIELD_W-1:0] f);
		logic [PIXEL_W:0] m;
		logic [PIXEL_W:0] sh;
		m  = (33'd1 << f[10:5]) - 33'd1;
		sh = m << f[4:0];
		return sh[PIXEL_W-1:0];
	endfunction

	// (v * (2^s - 1) + 127) / 255 without a divider.
	// With s = 8a + b: 2^s - 1 = 255 * 2^b * (1 + 2^8 + ...) + (2^b - 1), so the
	// result is v repeated a bytes, shifted by b, plus a small rounded term
	// (v * (2^b - 1) + 127) / 255 that stays below 2^b.
	function automatic logic [PIXEL_W-1:0] scale_chan(logic [7:0] v, logic [5:0] sz);
		logic [PIXEL_W-1:0] rep;
		logic [15:0]        y;
		logic [15:0]        q;
		logic [2:0]         b;
		rep = '0;
		b   = sz[2:0];
		for (int k = 0; k < 4; k++) begin
			if (sz[5:3] > 3'(k)) begin
				rep[8*k +: 8] = v;
			end
		end
		y = ({8'd0, v} << b) - {8'd0, v} + 16'd127;
		// exact y / 255 for y below 65535
		q = (y + 16'd1 + (y >> 8)) >> 8;
		return (rep << b) + {24'd0, q[7:0]};
	endfunction

endpackage

[rtl/rgb_pixel_format_packer.sv]
// RGB pixel format packer
//
// Converts one XRGB8888 / ARGB8888 source pixel into a packed destination
// pixel whose channel sizes and offsets come from the configuration registers.
//
// Channels:
//   input  - start with pixel_in; an item is taken at each clock edge with
//            start high and busy low. busy stays low: a pixel may be offered
//            in every cycle.
//   output - done strobes for one cycle with packed_out, byte_count, status.
//            The receiver cannot hold results off, so nothing ever stalls.
//   config - cfg_we / cfg_index / cfg_data write one register per edge; write
//            only while no item is in flight. Unknown indexes are dropped.
//
// Throughput is one pixel per cycle. The path is an input register,
// one pass of shift/add logic per channel, and the result register.
// Reset clears both pipeline valid bits and loads the default format
// (32 bpp, XRGB8888 with alpha 255 in the top byte).
module rgb_pixel_format_packer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [rpfp_pkg::PIXEL_W-1:0]        pixel_in,
	output logic                                done,
	output logic [rpfp_pkg::PIXEL_W-1:0]        packed_out,
	output logic [2:0]                          byte_count,
	output logic [1:0]                          status,
	input  logic                                cfg_we,
	input  logic [rpfp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rpfp_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// configuration registers
	logic [rpfp_pkg::BPP_W-1:0]   pixel_bits_q;
	logic [rpfp_pkg::FIELD_W-1:0] red_field_q;
	logic [rpfp_pkg::FIELD_W-1:0] green_field_q;
	logic [rpfp_pkg::FIELD_W-1:0] blue_field_q;
	logic [rpfp_pkg::FIELD_W-1:0] alpha_field_q;
	logic                         src_alpha_q;

	// stage 1: captured pixel
	logic                         vld_s1;
	logic [rpfp_pkg::PIXEL_W-1:0] pix_s1;

	// stage 2: result register
	logic                         done_s2;
	logic [rpfp_pkg::PIXEL_W-1:0] packed_s2;
	logic [2:0]                   count_s2;
	rpfp_pkg::status_t            status_s2;

	// format check
	logic                         width_ok;
	logic                         chan_ok;
	logic                         overlap;
	logic [rpfp_pkg::PIXEL_W-1:0] m_red, m_grn, m_blu, m_alp;
	rpfp_pkg::status_t            fmt_status;

	// packing
	logic [7:0]                   alpha_v;
	logic [rpfp_pkg::PIXEL_W-1:0] sc_red, sc_grn, sc_blu, sc_alp;
	logic [rpfp_pkg::PIXEL_W-1:0] packed_d;

	assign busy = 1'b0;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_bits_q  <= rpfp_pkg::PIXEL_BITS_RST;
			red_field_q   <= rpfp_pkg::RED_FIELD_RST;
			green_field_q <= rpfp_pkg::GREEN_FIELD_RST;
			blue_field_q  <= rpfp_pkg::BLUE_FIELD_RST;
			alpha_field_q <= rpfp_pkg::ALPHA_FIELD_RST;
			src_alpha_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rpfp_pkg::REG_PIXEL_BITS:  pixel_bits_q  <= cfg_data[rpfp_pkg::BPP_W-1:0];
				rpfp_pkg::REG_RED_FIELD:   red_field_q   <= cfg_data;
				rpfp_pkg::REG_GREEN_FIELD: green_field_q <= cfg_data;
				rpfp_pkg::REG_BLUE_FIELD:  blue_field_q  <= cfg_data;
				rpfp_pkg::REG_ALPHA_FIELD: alpha_field_q <= cfg_data;
				rpfp_pkg::REG_SRC_ALPHA:   src_alpha_q   <= cfg_data[0];
				default: ; // drop writes to unknown indexes
			endcase
		end
	end

	// Format check depends on configuration only; it is steady while items flow
	// if the user changes the registers only when the block is idle (not enforced).
	always_comb begin
		width_ok = (pixel_bits_q == 6'd16) || (pixel_bits_q == 6'd24) ||
			(pixel_bits_q == 6'd32);

		// red, green and blue must be non-empty; alpha may be empty
		chan_ok = (red_field_q[10:5] != 6'd0) &&
			rpfp_pkg::fld_fits(red_field_q, pixel_bits_q) &&
			(green_field_q[10:5] != 6'd0) &&
			rpfp_pkg::fld_fits(green_field_q, pixel_bits_q) &&
			(blue_field_q[10:5] != 6'd0) &&
			rpfp_pkg::fld_fits(blue_field_q, pixel_bits_q) &&
			((alpha_field_q[10:5] == 6'd0) ||
			rpfp_pkg::fld_fits(alpha_field_q, pixel_bits_q));

		m_red = rpfp_pkg::fld_mask(red_field_q);
		m_grn = rpfp_pkg::fld_mask(green_field_q);
		m_blu = rpfp_pkg::fld_mask(blue_field_q);
		m_alp = (alpha_field_q[10:5] == 6'd0) ? '0 : rpfp_pkg::fld_mask(alpha_field_q);

		// any pair sharing a bit; which pair is first does not change the code
		overlap = |((m_red & m_grn) | (m_red & m_blu) | (m_grn & m_blu) |
			((m_red | m_grn | m_blu) & m_alp));

		if (!width_ok) begin
			fmt_status = rpfp_pkg::ST_BAD_WIDTH;
		end else if (!chan_ok) begin
			fmt_status = rpfp_pkg::ST_BAD_CHANNEL;
		end else if (overlap) begin
			fmt_status = rpfp_pkg::ST_OVERLAP;
		end else begin
			fmt_status = rpfp_pkg::ST_OK;
		end
	end

	// Rescale each channel and place it at its offset
	always_comb begin
		alpha_v = src_alpha_q ? pix_s1[31:24] : 8'hFF;
		sc_red  = rpfp_pkg::scale_chan(pix_s1[23:16], red_field_q[10:5]);
		sc_grn  = rpfp_pkg::scale_chan(pix_s1[15:8], green_field_q[10:5]);
		sc_blu  = rpfp_pkg::scale_chan(pix_s1[7:0], blue_field_q[10:5]);
		sc_alp  = (alpha_field_q[10:5] == 6'd0) ? '0 :
			rpfp_pkg::scale_chan(alpha_v, alpha_field_q[10:5]);
		packed_d = (sc_red << red_field_q[4:0]) | (sc_grn << green_field_q[4:0]) |
			(sc_blu << blue_field_q[4:0]) | (sc_alp << alpha_field_q[4:0]);
	end

	// Capture the pixel; advance every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			pix_s1 <= pixel_in;
		end
	end

	// Result register; zero the payload on a format error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			status_s2 <= fmt_status;
			if (fmt_status == rpfp_pkg::ST_OK) begin
				packed_s2 <= packed_d;
				count_s2  <= pixel_bits_q[5:3];
			end else begin
				packed_s2 <= '0;
				count_s2  <= 3'd0;
			end
		end
	end

	assign done       = done_s2;
	assign packed_out = packed_s2;
	assign byte_count = count_s2;
	assign status     = status_s2;

endmodule

[rtl/rpfp_checker.sv]
module rpfp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic                            done,
	input logic [rpfp_pkg::PIXEL_W-1:0]    packed_out,
	input logic [2:0]                      byte_count,
	input logic [1:0]                      status
);

	// every accepted item yields its result through the input and result registers
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("accepted item produced no result");

	// no result without an accepted item
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without an accepted item");

	// an error result carries an empty payload
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != rpfp_pkg::ST_OK) |-> (packed_out == '0) && (byte_count == 3'd0))
		else $error("error result with nonzero payload");

	// a good result has a supported byte count
	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == rpfp_pkg::ST_OK) |->
		(byte_count == 3'd2) || (byte_count == 3'd3) || (byte_count == 3'd4))
		else $error("good result with bad byte count");

endmodule

bind rgb_pixel_format_packer rpfp_checker u_rpfp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.packed_out (packed_out),
	.byte_count (byte_count),
	.status     (status)
);
